// ===== rtl/core/ofifo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofifo_pkg
// Shared codes, field widths and the stored entry type of the order queue.
// ----------------------------------------------------------------------------
package ofifo_pkg;

  localparam int AMT_W     = 32;
  localparam int NUM_W     = 32;
  localparam int CNT_OUT_W = 7;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_RANGE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        [NUM_W-1:0] number;
    logic signed [AMT_W-1:0] amount;
  } entry_t;

endpackage

// ===== rtl/core/order_fifo_with_search_and_range.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_fifo_with_search_and_range
// Bounded FIFO of orders with pop, search by amount and lowest/highest query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries mode and amount; one transfer is
//   one operation. Output channel (out_valid/out_ready) returns exactly one
//   result per operation, in order. Entries live in one single-port-read RAM
//   and a small sequencer walks it through the equality and min/max compares,
//   one entry per cycle with a registered read.
//   Path from accept to out_valid:
//     push, or any operation on an empty queue: straight to the result stage
//     pop: takes the head entry
//     search: scans from the head up to the first hit, or over every held
//             entry on a miss
//     range: scans every held entry
//   One operation is in flight at a time; in_ready is high only while idle,
//   and an operation can be taken while the previous result still waits.
//   Reset (synchronous, active high) empties the queue and sets the next
//   order number to 1; the RAM is not cleared and needs no sweep.
//   If the receiver stalls, the finished result is held in the sequencer
//   until the output register frees up; no result is lost or repeated.
// ----------------------------------------------------------------------------
module order_fifo_with_search_and_range
  import ofifo_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic signed [AMT_W-1:0]     amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [NUM_W-1:0]            order_number,
  output logic signed [AMT_W-1:0]     entry_amount,
  output logic [CNT_OUT_W-1:0]        entry_count,
  output logic signed [AMT_W-1:0]     lowest_amount,
  output logic signed [AMT_W-1:0]     highest_amount
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  entry_t mem [QUEUE_DEPTH];

  logic [1:0]              state;
  logic [AW-1:0]           head;
  logic [AW-1:0]           tail;
  logic [CW-1:0]           held_count;
  logic [NUM_W-1:0]        next_number;
  logic [1:0]              cur_mode;
  logic signed [AMT_W-1:0] key;
  logic [AW-1:0]           rd_addr;
  logic [CW-1:0]           issue_cnt;
  logic [CW-1:0]           check_cnt;
  logic                    rd_vld;
  entry_t                  rd_data;
  logic [1:0]              res_status;
  logic [NUM_W-1:0]        res_number;
  logic signed [AMT_W-1:0] res_amount;
  logic signed [AMT_W-1:0] res_lo;
  logic signed [AMT_W-1:0] res_hi;

  logic                    rd_en;
  logic                    wr_en;
  logic                    full;
  logic                    empty;
  logic                    check_last;
  logic                    key_hit;
  logic                    scan_done;
  logic [CW+CNT_OUT_W-1:0] count_wide;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
    next_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign in_ready   = (state == S_IDLE);
  assign full       = (held_count == FULL_CNT);
  assign empty      = (held_count == '0);
  assign wr_en      = in_ready && in_valid && (mode == MODE_PUSH) && !full;
  assign rd_en      = (state == S_SCAN) && (issue_cnt != held_count);
  assign check_last = (check_cnt == held_count - 1'b1);
  assign key_hit    = (rd_data.amount == key);
  assign count_wide = (CW + CNT_OUT_W)'(held_count);

  always_comb begin
    scan_done = 1'b0;
    if (state == S_SCAN && rd_vld) begin
      case (cur_mode)
        MODE_POP:    scan_done = 1'b1;
        MODE_SEARCH: scan_done = key_hit || check_last;
        default:     scan_done = check_last;
      endcase
    end
  end

  // Entry RAM: one write port for push, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= '{number: next_number, amount: amount};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      tail        <= '0;
      held_count  <= '0;
      next_number <= NUM_W'(1);
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_mode <= mode;
            key      <= amount;
            res_lo   <= '0;
            res_hi   <= '0;
            if (mode == MODE_PUSH) begin
              if (full) begin
                res_status <= ST_FULL;
                res_number <= '0;
                res_amount <= '0;
              end else begin
                res_status  <= ST_OK;
                res_number  <= next_number;
                res_amount  <= amount;
                next_number <= next_number + 1'b1;
                tail        <= next_idx(tail);
                held_count  <= held_count + 1'b1;
              end
              state <= S_DONE;
            end else begin
              res_number <= '0;
              res_amount <= '0;
              if (empty) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                rd_addr    <= head;
                issue_cnt  <= '0;
                check_cnt  <= '0;
                state      <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          rd_vld <= rd_en && !scan_done;
          if (rd_en) begin
            rd_addr   <= next_idx(rd_addr);
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rd_vld) begin
            check_cnt <= check_cnt + 1'b1;
            case (cur_mode)
              MODE_POP: begin
                res_number <= rd_data.number;
                res_amount <= rd_data.amount;
                head       <= next_idx(head);
                held_count <= held_count - 1'b1;
              end
              MODE_SEARCH: begin
                if (key_hit) begin
                  res_number <= rd_data.number;
                  res_amount <= rd_data.amount;
                end else if (check_last) begin
                  res_status <= ST_NOTFOUND;
                end
              end
              default: begin
                // first entry seeds both bounds
                if (check_cnt == '0 || rd_data.amount < res_lo) begin
                  res_lo <= rd_data.amount;
                end
                if (check_cnt == '0 || rd_data.amount > res_hi) begin
                  res_hi <= rd_data.amount;
                end
              end
            endcase
          end
          if (scan_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            status         <= res_status;
            order_number   <= res_number;
            entry_amount   <= res_amount;
            entry_count    <= count_wide[CNT_OUT_W-1:0];
            lowest_amount  <= res_lo;
            highest_amount <= res_hi;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/order_fifo_with_search_and_range_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_fifo_with_search_and_range_tb
// Self-checking bench for the order queue. The bench keeps a queue model of
// the held orders and predicts status, number, amount, count and min/max for
// every accepted operation. A short directed table goes first. Random
// fill/drain segments with searches aimed at held amounts follow, under three
// idle patterns on the input and output channels.
// ----------------------------------------------------------------------------
module order_fifo_with_search_and_range_tb;
  import ofifo_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int RANDOM_OPS   = 950;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [1:0]           status;
    logic [NUM_W-1:0]     order_number;
    logic [AMT_W-1:0]     entry_amount;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [AMT_W-1:0]     lowest_amount;
    logic [AMT_W-1:0]     highest_amount;
  } order_result_t;

  typedef struct packed {
    logic                 typed;
    logic [1:0]           mode;
    logic [AMT_W-1:0]     amount;
    order_result_t        expected;
  } order_op_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              mode = MODE_PUSH;
  logic signed [AMT_W-1:0] amount = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic [NUM_W-1:0]        order_number;
  logic signed [AMT_W-1:0] entry_amount;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic signed [AMT_W-1:0] lowest_amount;
  logic signed [AMT_W-1:0] highest_amount;

  entry_t          held_orders[$];
  logic [NUM_W-1:0] next_order_num = 1;
  order_result_t   pending_results[$];
  order_op_t       directed_ops[$];
  int              send_idle_pct = 38;
  int              recv_idle_pct = 55;
  int              error_count = 0;
  int              cycle_count = 0;

  order_fifo_with_search_and_range #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .amount        (amount),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .order_number  (order_number),
    .entry_amount  (entry_amount),
    .entry_count   (entry_count),
    .lowest_amount (lowest_amount),
    .highest_amount(highest_amount)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Queue model: one operation in, one result out, state advanced in place.
  function automatic order_result_t predict_order_op(input logic [1:0] op,
                                                     input logic signed [AMT_W-1:0] amt);
    order_result_t           r;
    entry_t                  e;
    logic signed [AMT_W-1:0] mn;
    logic signed [AMT_W-1:0] mx;
    bit                      hit;
    r   = '0;
    hit = 1'b0;
    case (op)
      MODE_PUSH: begin
        if (held_orders.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          e.number = next_order_num;
          e.amount = amt;
          held_orders.push_back(e);
          r.order_number = next_order_num;
          r.entry_amount = amt;
          next_order_num = next_order_num + 1'b1;
        end
      end
      MODE_POP: begin
        if (held_orders.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = held_orders.pop_front();
          r.order_number = e.number;
          r.entry_amount = e.amount;
        end
      end
      MODE_SEARCH: begin
        if (held_orders.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // nearest the head wins
          foreach (held_orders[i]) begin
            if (!hit && held_orders[i].amount == amt) begin
              hit = 1'b1;
              r.order_number = held_orders[i].number;
              r.entry_amount = held_orders[i].amount;
            end
          end
          if (!hit) r.status = ST_NOTFOUND;
        end
      end
      default: begin
        if (held_orders.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          mn = held_orders[0].amount;
          mx = mn;
          foreach (held_orders[i]) begin
            if (held_orders[i].amount < mn) mn = held_orders[i].amount;
            if (held_orders[i].amount > mx) mx = held_orders[i].amount;
          end
          r.lowest_amount  = mn;
          r.highest_amount = mx;
        end
      end
    endcase
    r.entry_count = CNT_OUT_W'(held_orders.size());
    return r;
  endfunction

  function automatic order_op_t typed_op(input logic [1:0] op, input logic [AMT_W-1:0] amt,
                                         input logic [1:0] st, input logic [NUM_W-1:0] num,
                                         input logic [AMT_W-1:0] eamt,
                                         input logic [CNT_OUT_W-1:0] cnt,
                                         input logic [AMT_W-1:0] lo,
                                         input logic [AMT_W-1:0] hi);
    order_op_t o;
    o.typed    = 1'b1;
    o.mode     = op;
    o.amount   = amt;
    o.expected = '{st, num, eamt, cnt, lo, hi};
    return o;
  endfunction

  function automatic order_op_t model_op(input logic [1:0] op, input logic [AMT_W-1:0] amt);
    order_op_t o;
    o        = '0;
    o.mode   = op;
    o.amount = amt;
    return o;
  endfunction

  function automatic logic [AMT_W-1:0] random_amount();
    logic [AMT_W-1:0] a;
    case ($urandom_range(0, 9))
      0:       a = 32'h8000_0000;
      1:       a = 32'h7fff_ffff;
      2:       a = '0;
      3:       a = '1;
      4, 5, 6: a = $urandom_range(0, 7) - 3;  // small pool to force duplicates
      default: a = $urandom;
    endcase
    return a;
  endfunction

  // Present one operation, hold it until the transfer, then record the expectation.
  task automatic send_op(input order_op_t op);
    order_result_t exp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op.mode;
    amount   <= op.amount;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp = predict_order_op(op.mode, op.amount);
    if (op.typed) exp = op.expected;
    pending_results.push_back(exp);
  endtask

  // Output side: check each transfer and draw the next ready.
  always @(posedge clk) begin
    order_result_t exp;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("cycle %0d: result with no operation pending (st=%0d num=%0d)",
                   cycle_count, status, order_number);
      end else begin
        exp = pending_results.pop_front();
        if (status !== exp.status || order_number !== exp.order_number ||
            entry_amount !== exp.entry_amount || entry_count !== exp.entry_count ||
            lowest_amount !== exp.lowest_amount || highest_amount !== exp.highest_amount) begin
          error_count++;
          if (error_count <= 10) begin
            $display("cycle %0d: exp st=%0d num=%0d amt=%0d cnt=%0d lo=%0d hi=%0d",
                     cycle_count, exp.status, exp.order_number, $signed(exp.entry_amount),
                     exp.entry_count, $signed(exp.lowest_amount),
                     $signed(exp.highest_amount));
            $display("cycle %0d: got st=%0d num=%0d amt=%0d cnt=%0d lo=%0d hi=%0d",
                     cycle_count, status, order_number, entry_amount, entry_count,
                     lowest_amount, highest_amount);
          end
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("order_fifo_with_search_and_range: mismatch");
      $finish;
    end
  end

  initial begin
    int               sent;
    int               seg_len;
    int               push_w;
    int               pick;
    int               idx;
    logic [1:0]       op;
    logic [AMT_W-1:0] amt;

    directed_ops.push_back(typed_op(MODE_POP, 32'd0, ST_EMPTY, 0, 0, 0, 0, 0));
    directed_ops.push_back(typed_op(MODE_SEARCH, 32'd0, ST_EMPTY, 0, 0, 0, 0, 0));
    directed_ops.push_back(typed_op(MODE_RANGE, 32'hffff_ffff, ST_EMPTY, 0, 0, 0, 0, 0));
    directed_ops.push_back(typed_op(MODE_PUSH, 32'h8000_0000, ST_OK, 1, 32'h8000_0000, 1,
                                    0, 0));
    directed_ops.push_back(typed_op(MODE_RANGE, 32'd0, ST_OK, 0, 0, 1, 32'h8000_0000,
                                    32'h8000_0000));
    directed_ops.push_back(typed_op(MODE_PUSH, 32'h7fff_ffff, ST_OK, 2, 32'h7fff_ffff, 2,
                                    0, 0));
    directed_ops.push_back(typed_op(MODE_RANGE, 32'd0, ST_OK, 0, 0, 2, 32'h8000_0000,
                                    32'h7fff_ffff));
    // hit on the last held entry, then a miss over every entry
    directed_ops.push_back(typed_op(MODE_SEARCH, 32'h7fff_ffff, ST_OK, 2, 32'h7fff_ffff, 2,
                                    0, 0));
    directed_ops.push_back(typed_op(MODE_SEARCH, 32'd0, ST_NOTFOUND, 0, 0, 2, 0, 0));
    directed_ops.push_back(model_op(MODE_PUSH, 32'd0));
    directed_ops.push_back(model_op(MODE_PUSH, 32'hffff_ffff));
    directed_ops.push_back(model_op(MODE_PUSH, 32'd0));
    directed_ops.push_back(model_op(MODE_SEARCH, 32'd0));
    directed_ops.push_back(model_op(MODE_SEARCH, 32'hffff_ffff));
    directed_ops.push_back(model_op(MODE_SEARCH, 32'd1));
    directed_ops.push_back(model_op(MODE_RANGE, 32'h5555_5555));
    directed_ops.push_back(model_op(MODE_POP, 32'haaaa_aaaa));
    directed_ops.push_back(model_op(MODE_POP, 32'd0));
    directed_ops.push_back(model_op(MODE_RANGE, 32'd0));
    directed_ops.push_back(model_op(MODE_POP, 32'd0));
    directed_ops.push_back(model_op(MODE_POP, 32'd0));
    directed_ops.push_back(model_op(MODE_POP, 32'd0));
    directed_ops.push_back(typed_op(MODE_POP, 32'd0, ST_EMPTY, 0, 0, 0, 0, 0));
    directed_ops.push_back(model_op(MODE_PUSH, 32'd12345));
    directed_ops.push_back(model_op(MODE_SEARCH, 32'h5555_5555));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ops[i]) send_op(directed_ops[i]);

    // Random fill/drain segments; the first one is push heavy to reach full.
    sent = 0;
    while (sent < RANDOM_OPS) begin
      if (sent == 0) begin
        seg_len = 90;
        push_w  = 90;
      end else begin
        seg_len = $urandom_range(20, 60);
        case ($urandom_range(0, 4))
          0:       push_w = 85;
          1:       push_w = 15;
          2:       push_w = 30;
          3:       push_w = 70;
          default: push_w = 50;
        endcase
      end
      if (sent < RANDOM_OPS / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 55;
      end else if (sent < 2 * RANDOM_OPS / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < seg_len && sent < RANDOM_OPS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < push_w) op = MODE_PUSH;
        else case (pick % 3)
          0:       op = MODE_POP;
          1:       op = MODE_SEARCH;
          default: op = MODE_RANGE;
        endcase
        amt = random_amount();
        // aim most searches at a held amount, the tail entry now and then
        if (op == MODE_SEARCH && held_orders.size() > 0 && $urandom_range(0, 9) < 6) begin
          if ($urandom_range(0, 3) == 0) idx = held_orders.size() - 1;
          else idx = $urandom_range(0, held_orders.size() - 1);
          amt = held_orders[idx].amount;
        end
        send_op(model_op(op, amt));
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("order_fifo_with_search_and_range: match");
    end else begin
      $display("order_fifo_with_search_and_range: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ofifo_pkg.sv
rtl/core/order_fifo_with_search_and_range.sv
tb/order_fifo_with_search_and_range_tb.sv
